// File: src/mvcs_pkg.sv
// Package for the midpoint voltage charge sequencer.
// Holds the transaction payload types, phase and status codes, register map and reset values.
// No dependencies.
`timescale 1ns / 1ps

package mvcs_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [15:0] MonitorWaitMs = 16'd1000;
  localparam logic [13:0] Mask14 = 14'h3FFF;
  localparam logic [16:0] Max17 = 17'h1FFFF;

  localparam logic [7:0]  RstSaturationDuty = 8'd255;
  localparam logic [7:0]  RstSweepMinDuty = 8'd50;
  localparam logic [7:0]  RstSweepMaxDuty = 8'd255;
  localparam logic [7:0]  RstSweepStep = 8'd22;
  localparam logic [14:0] RstTempLimitMdeg = 15'd800;
  localparam logic [15:0] RstEvalIntervalMs = 16'd5000;
  localparam logic [13:0] RstSettleMs = 14'd200;
  localparam logic [15:0] RstUnloadedSettleMs = 16'd100;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_UNLOADED = 3'd1,
    PH_HIGHREF  = 3'd2,
    PH_SWEEP    = 3'd3,
    PH_MONITOR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_OVERTEMP  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ACT_START   = 1'b0,
    ACT_MEASURE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_SATURATION_DUTY    = 3'd0,
    REG_SWEEP_MIN_DUTY     = 3'd1,
    REG_SWEEP_MAX_DUTY     = 3'd2,
    REG_SWEEP_STEP         = 3'd3,
    REG_TEMP_LIMIT_MDEG    = 3'd4,
    REG_EVAL_INTERVAL_MS   = 3'd5,
    REG_SETTLE_MS          = 3'd6,
    REG_UNLOADED_SETTLE_MS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               action;
    logic [13:0]        batt_mv;
    logic signed [15:0] temp_diff_mdeg;
    logic [15:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic [15:0] wait_ms;
    logic [2:0]  phase;
    logic [1:0]  status;
    logic [13:0] target_mv;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  saturation_duty;
    logic [7:0]  sweep_min_duty;
    logic [7:0]  sweep_max_duty;
    logic [7:0]  sweep_step;
    logic [14:0] temp_limit_mdeg;
    logic [15:0] eval_interval_ms;
    logic [13:0] settle_ms;
    logic [15:0] unloaded_settle_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [13:0] unloaded_mv;
    logic [13:0] target_mv;
    logic [8:0]  sweep_duty;
    logic [7:0]  best_duty;
    logic [13:0] best_diff;
    logic [16:0] since_eval_ms;
    logic        have_best;
  } seq_state_t;

endpackage

// File: src/mvcs_regs.sv
// Configuration register file behind the APB-style port.
// Depends on mvcs_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module mvcs_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mvcs_pkg::cfg_t             cfg
);

  mvcs_pkg::cfg_t     cfg_r;
  mvcs_pkg::cfg_t     cfg_nxt;
  mvcs_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = mvcs_pkg::reg_idx_t'(paddr[mvcs_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        mvcs_pkg::REG_SATURATION_DUTY:    cfg_nxt.saturation_duty = pwdata[7:0];
        mvcs_pkg::REG_SWEEP_MIN_DUTY:     cfg_nxt.sweep_min_duty = pwdata[7:0];
        mvcs_pkg::REG_SWEEP_MAX_DUTY:     cfg_nxt.sweep_max_duty = pwdata[7:0];
        mvcs_pkg::REG_SWEEP_STEP:         cfg_nxt.sweep_step = pwdata[7:0];
        mvcs_pkg::REG_TEMP_LIMIT_MDEG:    cfg_nxt.temp_limit_mdeg = pwdata[14:0];
        mvcs_pkg::REG_EVAL_INTERVAL_MS:   cfg_nxt.eval_interval_ms = pwdata[15:0];
        mvcs_pkg::REG_SETTLE_MS:          cfg_nxt.settle_ms = pwdata[13:0];
        mvcs_pkg::REG_UNLOADED_SETTLE_MS: cfg_nxt.unloaded_settle_ms = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mvcs_pkg::REG_SATURATION_DUTY:    prdata = {24'd0, cfg_r.saturation_duty};
      mvcs_pkg::REG_SWEEP_MIN_DUTY:     prdata = {24'd0, cfg_r.sweep_min_duty};
      mvcs_pkg::REG_SWEEP_MAX_DUTY:     prdata = {24'd0, cfg_r.sweep_max_duty};
      mvcs_pkg::REG_SWEEP_STEP:         prdata = {24'd0, cfg_r.sweep_step};
      mvcs_pkg::REG_TEMP_LIMIT_MDEG:    prdata = {17'd0, cfg_r.temp_limit_mdeg};
      mvcs_pkg::REG_EVAL_INTERVAL_MS:   prdata = {16'd0, cfg_r.eval_interval_ms};
      mvcs_pkg::REG_SETTLE_MS:          prdata = {18'd0, cfg_r.settle_ms};
      mvcs_pkg::REG_UNLOADED_SETTLE_MS: prdata = {16'd0, cfg_r.unloaded_settle_ms};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.saturation_duty    <= mvcs_pkg::RstSaturationDuty;
      cfg_r.sweep_min_duty     <= mvcs_pkg::RstSweepMinDuty;
      cfg_r.sweep_max_duty     <= mvcs_pkg::RstSweepMaxDuty;
      cfg_r.sweep_step         <= mvcs_pkg::RstSweepStep;
      cfg_r.temp_limit_mdeg    <= mvcs_pkg::RstTempLimitMdeg;
      cfg_r.eval_interval_ms   <= mvcs_pkg::RstEvalIntervalMs;
      cfg_r.settle_ms          <= mvcs_pkg::RstSettleMs;
      cfg_r.unloaded_settle_ms <= mvcs_pkg::RstUnloadedSettleMs;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/mvcs_step.sv
// Per-transaction sequencer step: next phase, next state and the result item.
// Purely combinational; depends on mvcs_pkg for types and codes.
`timescale 1ns / 1ps

module mvcs_step (
  input  mvcs_pkg::seq_state_t st,
  input  mvcs_pkg::cfg_t       cfg,
  input  mvcs_pkg::in_item_t   item,
  output mvcs_pkg::seq_state_t st_nxt,
  output mvcs_pkg::out_item_t  res
);

  mvcs_pkg::phase_t phase_nxt;
  logic [8:0]  high_sum;
  logic [7:0]  high_duty;
  logic [16:0] ref_prod;
  logic [15:0] ref_wait;
  logic [14:0] mid_sum;
  logic [13:0] diff;
  logic [7:0]  step_eff;
  logic [8:0]  sweep_next;
  logic        sweep_more;
  logic        take_best;
  logic        empty_sweep;
  logic        over_temp;
  logic [17:0] since_sum;
  logic [16:0] since_sat;
  logic        reach;
  logic [7:0]  applied_duty;
  logic [7:0]  best_new;

  assign high_sum    = {1'b0, 8'd255} + {1'b0, cfg.saturation_duty};
  assign high_duty   = high_sum[8:1];
  assign ref_prod    = {cfg.settle_ms, 2'b00} + {3'd0, cfg.settle_ms};
  assign ref_wait    = ref_prod[16] ? 16'hFFFF : ref_prod[15:0];
  assign mid_sum     = {1'b0, st.unloaded_mv} + {1'b0, item.batt_mv};
  assign diff        = (item.batt_mv >= st.target_mv) ? item.batt_mv - st.target_mv
                                                      : st.target_mv - item.batt_mv;
  assign step_eff    = (cfg.sweep_step == 8'd0) ? 8'd1 : cfg.sweep_step;
  assign sweep_next  = {1'b0, st.sweep_duty[7:0]} + {1'b0, step_eff};
  assign sweep_more  = sweep_next <= {1'b0, cfg.sweep_max_duty};
  assign take_best   = !st.have_best || (diff < st.best_diff);
  assign best_new    = take_best ? st.sweep_duty[7:0] : st.best_duty;
  assign empty_sweep = cfg.sweep_min_duty > cfg.sweep_max_duty;
  assign over_temp   = item.temp_diff_mdeg > $signed({1'b0, cfg.temp_limit_mdeg});
  assign since_sum   = {1'b0, st.since_eval_ms} + {2'd0, item.elapsed_ms};
  assign since_sat   = since_sum[17] ? mvcs_pkg::Max17 : since_sum[16:0];
  assign reach       = since_sat >= {1'b0, cfg.eval_interval_ms};

  always_comb begin
    case (st.phase)
      mvcs_pkg::PH_HIGHREF: applied_duty = high_duty;
      mvcs_pkg::PH_SWEEP:   applied_duty = st.sweep_duty[7:0];
      mvcs_pkg::PH_MONITOR: applied_duty = st.best_duty;
      default:              applied_duty = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt = st.phase;
    if (item.action == mvcs_pkg::ACT_START) begin
      if (st.phase == mvcs_pkg::PH_IDLE) begin
        phase_nxt = mvcs_pkg::PH_UNLOADED;
      end
    end else begin
      case (st.phase)
        mvcs_pkg::PH_UNLOADED: phase_nxt = mvcs_pkg::PH_HIGHREF;
        mvcs_pkg::PH_HIGHREF:  phase_nxt = empty_sweep ? mvcs_pkg::PH_MONITOR
                                                       : mvcs_pkg::PH_SWEEP;
        mvcs_pkg::PH_SWEEP:    phase_nxt = sweep_more ? mvcs_pkg::PH_SWEEP
                                                      : mvcs_pkg::PH_MONITOR;
        mvcs_pkg::PH_MONITOR: begin
          if (over_temp) begin
            phase_nxt = mvcs_pkg::PH_IDLE;
          end else if (reach) begin
            phase_nxt = mvcs_pkg::PH_UNLOADED;
          end else begin
            phase_nxt = mvcs_pkg::PH_MONITOR;
          end
        end
        default: phase_nxt = mvcs_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    st_nxt       = st;
    st_nxt.phase = phase_nxt;
    res          = '0;
    if (item.action == mvcs_pkg::ACT_START) begin
      if (st.phase != mvcs_pkg::PH_IDLE) begin
        res.duty   = applied_duty;
        res.status = mvcs_pkg::ST_RUNNING;
      end else begin
        st_nxt.best_duty     = 8'd0;
        st_nxt.since_eval_ms = 17'd0;
        res.wait_ms          = cfg.unloaded_settle_ms;
      end
    end else begin
      case (st.phase)
        mvcs_pkg::PH_UNLOADED: begin
          st_nxt.unloaded_mv = item.batt_mv;
          res.duty           = high_duty;
          res.wait_ms        = ref_wait;
        end
        mvcs_pkg::PH_HIGHREF: begin
          st_nxt.target_mv = mid_sum[14:1];
          st_nxt.best_diff = mvcs_pkg::Mask14;
          st_nxt.have_best = 1'b0;
          if (empty_sweep) begin
            st_nxt.since_eval_ms = 17'd0;
            res.duty             = st.best_duty;
          end else begin
            st_nxt.sweep_duty = {1'b0, cfg.sweep_min_duty};
            res.duty          = cfg.sweep_min_duty;
            res.wait_ms       = {2'd0, cfg.settle_ms};
          end
        end
        mvcs_pkg::PH_SWEEP: begin
          if (take_best) begin
            st_nxt.best_diff = diff;
            st_nxt.best_duty = st.sweep_duty[7:0];
            st_nxt.have_best = 1'b1;
          end
          if (sweep_more) begin
            st_nxt.sweep_duty = sweep_next;
            res.duty          = sweep_next[7:0];
            res.wait_ms       = {2'd0, cfg.settle_ms};
          end else begin
            st_nxt.since_eval_ms = 17'd0;
            res.duty             = best_new;
          end
        end
        mvcs_pkg::PH_MONITOR: begin
          if (over_temp) begin
            res.status = mvcs_pkg::ST_OVERTEMP;
          end else if (reach) begin
            st_nxt.since_eval_ms = 17'd0;
            res.wait_ms          = cfg.unloaded_settle_ms;
          end else begin
            st_nxt.since_eval_ms = since_sat;
            res.duty             = st.best_duty;
            res.wait_ms          = mvcs_pkg::MonitorWaitMs;
          end
        end
        default: res.status = mvcs_pkg::ST_IGNORED;
      endcase
    end
    res.phase     = phase_nxt;
    res.target_mv = st_nxt.target_mv;
  end

endmodule

// File: src/midpoint_voltage_charge_sequencer_unit.sv
// Top level of the midpoint voltage charge sequencer.
// Depends on mvcs_pkg, mvcs_regs and mvcs_step.
`timescale 1ns / 1ps

// One measurement or start transaction in, one result transaction out. Each
// transaction is held in the input register, where the sequencer step is
// evaluated against the current state, and then in the output register until
// taken; a new transaction is taken every cycle as long as the result side
// keeps up. Throughput is set by the single state update per cycle. The user
// must write registers over the APB-style port only while no transaction is
// in flight (not enforced by the block); there is no clearing pass after reset.
module midpoint_voltage_charge_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mvcs_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mvcs_pkg::out_item_t        out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  mvcs_pkg::cfg_t       cfg;
  mvcs_pkg::in_item_t   in_q_r;
  logic                 in_valid_r;
  mvcs_pkg::out_item_t  out_q_r;
  logic                 out_valid_r;
  mvcs_pkg::seq_state_t state_r;
  mvcs_pkg::seq_state_t state_nxt;
  mvcs_pkg::out_item_t  res;
  logic                 advance;

  mvcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mvcs_step u_step (
    .st     (state_r),
    .cfg    (cfg),
    .item   (in_q_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  assign advance   = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~in_valid_r | advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
    if (advance) begin
      out_q_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= mvcs_pkg::PH_IDLE;
      state_r.unloaded_mv   <= 14'd0;
      state_r.target_mv     <= 14'd0;
      state_r.sweep_duty    <= 9'd0;
      state_r.best_duty     <= 8'd0;
      state_r.best_diff     <= mvcs_pkg::Mask14;
      state_r.since_eval_ms <= 17'd0;
      state_r.have_best     <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after a step");

  a_overtemp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_q_r.status == mvcs_pkg::ST_OVERTEMP) |->
      (out_q_r.phase == mvcs_pkg::PH_IDLE && out_q_r.duty == 8'd0))
    else $error("over-temperature result without idle phase and zero duty");

  a_idle_measure_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.phase == mvcs_pkg::PH_IDLE &&
     in_q_r.action == mvcs_pkg::ACT_MEASURE) |=> state_r.phase == mvcs_pkg::PH_IDLE)
    else $error("measurement while idle left idle");
`endif

endmodule
